// ===== rtl/gmbs_pkg.sv =====
// ----------------------------------------------------------------------------
// gmbs_pkg
// shared constants and types of the gradient max block sampler
// ----------------------------------------------------------------------------
package gmbs_pkg;

    localparam int MAX_WIDTH   = 2048;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int MAX_BLOCK   = 16;
    localparam int LOC_W       = $clog2(MAX_BLOCK);
    localparam int SAMPLE_BITS = 16;
    localparam int NCH         = 4;
    localparam int PIX_W       = SAMPLE_BITS * NCH;
    localparam int ROW_W       = 12;
    localparam int REG_W       = 12;
    localparam int BS_W        = 5;
    localparam int IDX_W       = 2;
    localparam int OFIFO_DEPTH = 8;
    localparam int OFIFO_AW    = $clog2(OFIFO_DEPTH);

    localparam logic [IDX_W-1:0] CFG_ROI_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] CFG_ROI_HEIGHT = 2'd1;
    localparam logic [IDX_W-1:0] CFG_BLOCK_SIZE = 2'd2;

    typedef logic [PIX_W-1:0] pix_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] grad;
        pix_t                   pix;
    } best_t;

    typedef struct packed {
        logic             last;
        logic [ROW_W-1:0] by;
        logic [COL_W-1:0] bx;
        pix_t             pix;
    } result_t;

    typedef struct packed {
        logic    push0;
        logic    push1;
        result_t din0;
        result_t din1;
    } fifo_push_t;

endpackage

// ===== rtl/gmbs_ram.sv =====
// ----------------------------------------------------------------------------
// gmbs_ram
// single write, single read synchronous ram, write-first on an address match
// ----------------------------------------------------------------------------
module gmbs_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 2048,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            if (we && (waddr == raddr))
            begin
                rdata_reg <= wdata;
            end
            else
            begin
                rdata_reg <= mem[raddr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/gmbs_out_fifo.sv =====
// ----------------------------------------------------------------------------
// gmbs_out_fifo
// result queue, takes up to two results a cycle and hands out one
// ----------------------------------------------------------------------------
module gmbs_out_fifo (
    input  logic                      clk,
    input  logic                      rst_n,
    input  gmbs_pkg::fifo_push_t      push,
    input  logic                      pop,
    output gmbs_pkg::result_t         head,
    output logic [gmbs_pkg::OFIFO_AW:0] count
);

    gmbs_pkg::result_t               entry [gmbs_pkg::OFIFO_DEPTH];
    logic [gmbs_pkg::OFIFO_AW-1:0]   wr_ptr_reg;
    logic [gmbs_pkg::OFIFO_AW-1:0]   wr_ptr_next;
    logic [gmbs_pkg::OFIFO_AW-1:0]   rd_ptr_reg;
    logic [gmbs_pkg::OFIFO_AW-1:0]   rd_ptr_next;
    logic [gmbs_pkg::OFIFO_AW:0]     count_reg;
    logic [gmbs_pkg::OFIFO_AW:0]     count_next;
    logic [gmbs_pkg::OFIFO_AW:0]     n_in;
    logic [gmbs_pkg::OFIFO_AW-1:0]   wr_ptr_p1;

    assign wr_ptr_p1 = wr_ptr_reg + 1'b1;

    always_comb
    begin
        n_in        = {{gmbs_pkg::OFIFO_AW{1'b0}}, push.push0}
                    + {{gmbs_pkg::OFIFO_AW{1'b0}}, push.push1};
        wr_ptr_next = wr_ptr_reg + n_in[gmbs_pkg::OFIFO_AW-1:0];
        rd_ptr_next = rd_ptr_reg + {{(gmbs_pkg::OFIFO_AW-1){1'b0}}, pop};
        count_next  = count_reg + n_in - {{gmbs_pkg::OFIFO_AW{1'b0}}, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.push0)
        begin
            entry[wr_ptr_reg] <= push.din0;
        end
        if (push.push1)
        begin
            entry[wr_ptr_p1] <= push.din1;
        end
    end

    assign head  = entry[rd_ptr_reg];
    assign count = count_reg;

endmodule

// ===== rtl/gradient_max_block_sampler_unit.sv =====
// ----------------------------------------------------------------------------
// gradient_max_block_sampler_unit
// picks the highest gradient pixel of every square block of a raster region
// ----------------------------------------------------------------------------
//  channel   direction  contents
//  s_*       in         pixel request: tdata = ch0, ch1, ch2, ch3
//  m_*       out        sample request: tdata = ch0..ch3, block_x, block_y;
//                       tlast = last_in_run
//  cfg_*     in         register write: roi_width, roi_height, block_size
//
//  one pixel per cycle; each pixel is read from the line rams in the cycle it
//  is taken and evaluated, written back and queued in the cycle after
//  up to two samples per pixel go to an eight deep queue; the input stalls
//  only when that queue could not absorb the pixel in flight plus one more
//  reset clears counters and queue; ram contents need no clearing
//  a write to any of the three registers restarts the frame at the top-left pixel
// ----------------------------------------------------------------------------
module gradient_max_block_sampler_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [63:0]                   s_tdata,   // pix_ch0, pix_ch1, pix_ch2, pix_ch3
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [87:0]                   m_tdata,   // sel_ch0..sel_ch3, block_x, block_y
    output logic                          m_tlast,
    input  logic                          cfg_we,
    input  logic [gmbs_pkg::IDX_W-1:0]    cfg_index,
    input  logic [gmbs_pkg::REG_W-1:0]    cfg_data
);

    localparam int CW = gmbs_pkg::COL_W;
    localparam int RW = gmbs_pkg::ROW_W;
    localparam int LW = gmbs_pkg::LOC_W;
    localparam int SB = gmbs_pkg::SAMPLE_BITS;
    localparam int BW = $bits(gmbs_pkg::best_t);

    // configuration
    logic [gmbs_pkg::REG_W-1:0] roi_width_reg;
    logic [gmbs_pkg::REG_W-1:0] roi_height_reg;
    logic [gmbs_pkg::BS_W-1:0]  block_size_reg;
    logic [gmbs_pkg::REG_W-1:0] w_eff;
    logic [gmbs_pkg::REG_W-1:0] h_eff;
    logic [gmbs_pkg::BS_W-1:0]  bs_eff;
    logic [gmbs_pkg::REG_W-1:0] w_m1_full;
    logic [gmbs_pkg::BS_W-1:0]  bs_m1_full;
    logic [CW-1:0]              w_m1;
    logic [RW-1:0]              h_m1;
    logic [LW-1:0]              bs_m1;
    logic                       multi;
    logic                       cfg_hit;

    // scan position of the next pixel
    logic [CW-1:0] col_reg,  col_next;
    logic [RW-1:0] row_reg,  row_next;
    logic [LW-1:0] lx_reg,   lx_next;
    logic [CW-1:0] bx_reg,   bx_next;
    logic [LW-1:0] ly_reg,   ly_next;
    logic [RW-1:0] by_reg,   by_next;
    logic [LW-1:0] lym1_reg, lym1_next;
    logic [RW-1:0] bym1_reg, bym1_next;
    logic          accept;
    logic          col_last;
    logic          row_last;
    logic [CW-1:0] mid_raddr;

    // evaluation stage
    logic                   s2_valid_reg;
    gmbs_pkg::pix_t         s2_pix_reg;
    gmbs_pkg::pix_t         s2_cc_reg;
    logic [CW-1:0]          s2_x_reg;
    logic                   s2_x_zero_reg;
    logic                   s2_x_one_reg;
    logic                   s2_x_last_reg;
    logic                   s2_row_nz_reg;
    logic                   s2_row_one_reg;
    logic                   s2_last_row_reg;
    logic [LW-1:0]          s2_lx_reg;
    logic [CW-1:0]          s2_bx_reg;
    logic [LW-1:0]          s2_ly_reg;
    logic [RW-1:0]          s2_by_reg;
    logic [LW-1:0]          s2_lym1_reg;
    logic [RW-1:0]          s2_bym1_reg;
    logic [LW-1:0]          s2_lxp_reg;
    logic [CW-1:0]          s2_bxp_reg;
    gmbs_pkg::pix_t         last_pix_reg;
    logic [SB-1:0]          last2_ch0_reg;
    logic [SB-1:0]          prev_cc_reg;
    gmbs_pkg::best_t        cur_reg;

    gmbs_pkg::pix_t         mid_q;
    logic [SB-1:0]          up_q;
    logic [BW-1:0]          blk_q_raw;
    gmbs_pkg::best_t        blk_q;

    gmbs_pkg::pix_t         cc_full;
    logic [SB-1:0]          cc0;
    logic [SB-1:0]          p0;
    logic [SB-1:0]          r_nb;
    logic [SB-1:0]          u_nb;
    logic [SB-1:0]          ga;
    logic [SB-1:0]          ccl;
    logic [SB-1:0]          ul;
    logic [SB-1:0]          gb;
    gmbs_pkg::best_t        c_start;
    gmbs_pkg::best_t        c_a;
    gmbs_pkg::best_t        tb_in;
    gmbs_pkg::best_t        t_b;
    gmbs_pkg::best_t        c_b;
    gmbs_pkg::best_t        p_b;
    gmbs_pkg::best_t        c_c;
    logic                   do_a, do_b, do_c;
    logic                   e_a, e_b, e_c, e_1;
    logic                   lx_zero;
    gmbs_pkg::result_t      r_a, r_b, r_c, r_1;
    gmbs_pkg::fifo_push_t   push;
    logic [1:0]             n_res;

    logic                   blk_we;
    logic [CW-1:0]          blk_waddr;
    gmbs_pkg::best_t        blk_wdata;

    gmbs_pkg::result_t      head;
    logic [gmbs_pkg::OFIFO_AW:0] fifo_count;
    logic [gmbs_pkg::OFIFO_AW+1:0] fifo_need;

    function automatic logic [SB-1:0] adiff(input logic [SB-1:0] a, input logic [SB-1:0] b);
        adiff = (a > b) ? (a - b) : (b - a);
    endfunction

    function automatic logic [SB-1:0] max2(input logic [SB-1:0] a, input logic [SB-1:0] b);
        max2 = (a > b) ? a : b;
    endfunction

    function automatic gmbs_pkg::best_t acc(input gmbs_pkg::best_t b, input logic [SB-1:0] g,
                                            input gmbs_pkg::pix_t pix, input logic first);
        gmbs_pkg::best_t res;
        res = b;
        if (first || (g > b.grad))
        begin
            res.grad = g;
            res.pix  = pix;
        end
        acc = res;
    endfunction

    // effective register values
    always_comb
    begin
        if (roi_width_reg == '0)
        begin
            w_eff = 12'd1;
        end
        else if (roi_width_reg > 12'(gmbs_pkg::MAX_WIDTH))
        begin
            w_eff = 12'(gmbs_pkg::MAX_WIDTH);
        end
        else
        begin
            w_eff = roi_width_reg;
        end
        h_eff = (roi_height_reg == '0) ? 12'd1 : roi_height_reg;
        if (block_size_reg == '0)
        begin
            bs_eff = 5'd1;
        end
        else if (block_size_reg > 5'(gmbs_pkg::MAX_BLOCK))
        begin
            bs_eff = 5'(gmbs_pkg::MAX_BLOCK);
        end
        else
        begin
            bs_eff = block_size_reg;
        end
        w_m1_full  = w_eff - 1'b1;
        bs_m1_full = bs_eff - 1'b1;
    end

    assign w_m1  = w_m1_full[CW-1:0];
    assign h_m1  = h_eff - 1'b1;
    assign bs_m1 = bs_m1_full[LW-1:0];
    assign multi = (bs_eff != 5'd1);

    assign cfg_hit = cfg_we && ((cfg_index == gmbs_pkg::CFG_ROI_WIDTH)
                             || (cfg_index == gmbs_pkg::CFG_ROI_HEIGHT)
                             || (cfg_index == gmbs_pkg::CFG_BLOCK_SIZE));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            roi_width_reg  <= 12'd64;
            roi_height_reg <= 12'd64;
            block_size_reg <= 5'd2;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                gmbs_pkg::CFG_ROI_WIDTH:  roi_width_reg  <= cfg_data;
                gmbs_pkg::CFG_ROI_HEIGHT: roi_height_reg <= cfg_data;
                gmbs_pkg::CFG_BLOCK_SIZE: block_size_reg <= cfg_data[gmbs_pkg::BS_W-1:0];
                default:                  roi_width_reg  <= roi_width_reg;
            endcase
        end
    end

    // scan counters
    assign fifo_need = {1'b0, fifo_count} + (s2_valid_reg ? 5'd2 : 5'd0);
    assign s_tready  = (fifo_need <= 5'(gmbs_pkg::OFIFO_DEPTH - 2));
    assign accept    = s_tvalid && s_tready;
    assign col_last  = (col_reg == w_m1);
    assign row_last  = (row_reg == h_m1);
    assign mid_raddr = col_last ? '0 : (col_reg + 1'b1);

    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        lx_next   = lx_reg;
        bx_next   = bx_reg;
        ly_next   = ly_reg;
        by_next   = by_reg;
        lym1_next = lym1_reg;
        bym1_next = bym1_reg;
        if (cfg_hit)
        begin
            col_next = '0;
            row_next = '0;
            lx_next  = '0;
            bx_next  = '0;
            ly_next  = '0;
            by_next  = '0;
        end
        else if (accept)
        begin
            if (col_last)
            begin
                col_next  = '0;
                lx_next   = '0;
                bx_next   = '0;
                lym1_next = ly_reg;
                bym1_next = by_reg;
                if (row_last)
                begin
                    row_next = '0;
                    ly_next  = '0;
                    by_next  = '0;
                end
                else
                begin
                    row_next = row_reg + 1'b1;
                    if (ly_reg == bs_m1)
                    begin
                        ly_next = '0;
                        by_next = by_reg + 1'b1;
                    end
                    else
                    begin
                        ly_next = ly_reg + 1'b1;
                    end
                end
            end
            else
            begin
                col_next = col_reg + 1'b1;
                if (lx_reg == bs_m1)
                begin
                    lx_next = '0;
                    bx_next = bx_reg + 1'b1;
                end
                else
                begin
                    lx_next = lx_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            lx_reg       <= '0;
            bx_reg       <= '0;
            ly_reg       <= '0;
            by_reg       <= '0;
            lym1_reg     <= '0;
            bym1_reg     <= '0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            lx_reg       <= lx_next;
            bx_reg       <= bx_next;
            ly_reg       <= ly_next;
            by_reg       <= by_next;
            lym1_reg     <= lym1_next;
            bym1_reg     <= bym1_next;
            s2_valid_reg <= accept;
        end
    end

    // request held for evaluation
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s2_pix_reg      <= s_tdata;
            s2_cc_reg       <= mid_q;
            s2_x_reg        <= col_reg;
            s2_x_zero_reg   <= (col_reg == '0);
            s2_x_one_reg    <= (col_reg == CW'(1));
            s2_x_last_reg   <= col_last;
            s2_row_nz_reg   <= (row_reg != '0);
            s2_row_one_reg  <= (row_reg == RW'(1));
            s2_last_row_reg <= row_last;
            s2_lx_reg       <= lx_reg;
            s2_bx_reg       <= bx_reg;
            s2_ly_reg       <= ly_reg;
            s2_by_reg       <= by_reg;
            s2_lym1_reg     <= lym1_reg;
            s2_bym1_reg     <= bym1_reg;
            s2_lxp_reg      <= s2_lx_reg;
            s2_bxp_reg      <= s2_bx_reg;
        end
        if (s2_valid_reg)
        begin
            last_pix_reg  <= s2_pix_reg;
            last2_ch0_reg <= last_pix_reg[SB-1:0];
            prev_cc_reg   <= cc0;
            cur_reg       <= c_c;
        end
    end

    // line and block memories
    gmbs_ram #(
        .DATA_W (gmbs_pkg::PIX_W),
        .DEPTH  (gmbs_pkg::MAX_WIDTH)
    ) u_mid_ram (
        .clk   (clk),
        .we    (s2_valid_reg),
        .waddr (s2_x_reg),
        .wdata (s2_pix_reg),
        .re    (accept),
        .raddr (mid_raddr),
        .rdata (mid_q)
    );

    gmbs_ram #(
        .DATA_W (SB),
        .DEPTH  (gmbs_pkg::MAX_WIDTH)
    ) u_upper_ram (
        .clk   (clk),
        .we    (s2_valid_reg && s2_row_nz_reg),
        .waddr (s2_x_reg),
        .wdata (cc0),
        .re    (accept),
        .raddr (col_reg),
        .rdata (up_q)
    );

    gmbs_ram #(
        .DATA_W (BW),
        .DEPTH  (gmbs_pkg::MAX_WIDTH)
    ) u_best_ram (
        .clk   (clk),
        .we    (blk_we),
        .waddr (blk_waddr),
        .wdata (blk_wdata),
        .re    (accept),
        .raddr (bx_reg),
        .rdata (blk_q_raw)
    );

    assign blk_q = blk_q_raw;

    // gradients
    always_comb
    begin
        cc_full = (w_m1 == '0) ? last_pix_reg : s2_cc_reg;
        cc0     = cc_full[SB-1:0];
        p0      = s2_pix_reg[SB-1:0];
        r_nb    = s2_x_last_reg ? cc0 : mid_q[SB-1:0];
        u_nb    = s2_row_one_reg ? cc0 : up_q;
        if (s2_x_zero_reg || s2_x_last_reg)
        begin
            ga = '0;
        end
        else
        begin
            ga = max2(max2(adiff(cc0, prev_cc_reg), adiff(cc0, r_nb)),
                      max2(adiff(cc0, u_nb), adiff(cc0, p0)));
        end
        ccl = last_pix_reg[SB-1:0];
        ul  = s2_row_nz_reg ? prev_cc_reg : ccl;
        if (s2_x_one_reg)
        begin
            gb = '0;
        end
        else
        begin
            gb = max2(max2(adiff(ccl, last2_ch0_reg), adiff(ccl, p0)), adiff(ccl, ul));
        end
    end

    // block updates in model order: upper row pixel, lagging last row pixel, row end
    always_comb
    begin
        lx_zero = (s2_lx_reg == '0);
        c_start = lx_zero ? blk_q : cur_reg;
        do_a    = multi && s2_row_nz_reg;
        do_b    = multi && s2_last_row_reg && !s2_x_zero_reg;
        do_c    = multi && s2_last_row_reg && s2_x_last_reg;
        c_a     = do_a ? acc(c_start, ga, cc_full, lx_zero && (s2_lym1_reg == '0)) : c_start;
        tb_in   = lx_zero ? cur_reg : c_a;
        t_b     = do_b ? acc(tb_in, gb, last_pix_reg,
                             (s2_lxp_reg == '0) && (s2_ly_reg == '0)) : tb_in;
        c_b     = lx_zero ? c_a : t_b;
        p_b     = lx_zero ? t_b : cur_reg;
        c_c     = do_c ? acc(c_b, '0, s2_pix_reg, lx_zero && (s2_ly_reg == '0)) : c_b;
        e_a     = s2_valid_reg && do_a && (s2_lx_reg == bs_m1) && (s2_lym1_reg == bs_m1);
        e_b     = s2_valid_reg && do_b && (s2_lxp_reg == bs_m1) && (s2_ly_reg == bs_m1);
        e_c     = s2_valid_reg && do_c && (s2_lx_reg == bs_m1) && (s2_ly_reg == bs_m1);
        e_1     = s2_valid_reg && !multi;

        blk_we    = s2_valid_reg && multi && ((lx_zero && !s2_x_zero_reg) || s2_x_last_reg);
        blk_waddr = (lx_zero && !s2_x_zero_reg) ? s2_bxp_reg : s2_bx_reg;
        blk_wdata = (lx_zero && !s2_x_zero_reg) ? p_b : c_c;
    end

    // results
    always_comb
    begin
        r_a      = '{last: 1'b0, by: s2_bym1_reg, bx: s2_bx_reg,  pix: c_a.pix};
        r_b      = '{last: 1'b0, by: s2_by_reg,   bx: s2_bxp_reg, pix: t_b.pix};
        r_c      = '{last: 1'b0, by: s2_by_reg,   bx: s2_bx_reg,  pix: c_c.pix};
        r_1      = '{last: 1'b0, by: s2_by_reg,   bx: s2_bx_reg,  pix: s2_pix_reg};
        n_res    = {1'b0, e_1} + {1'b0, e_a} + {1'b0, e_b} + {1'b0, e_c};
        push.push0 = (n_res != 2'd0);
        push.push1 = (n_res == 2'd2);
        if (e_1)
        begin
            push.din0 = r_1;
        end
        else if (e_a)
        begin
            push.din0 = r_a;
        end
        else if (e_b)
        begin
            push.din0 = r_b;
        end
        else
        begin
            push.din0 = r_c;
        end
        push.din0.last = (n_res == 2'd1);
        push.din1      = (e_a && e_b) ? r_b : r_c;
        push.din1.last = 1'b1;
    end

    gmbs_out_fifo u_out_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (m_tvalid && m_tready),
        .head  (head),
        .count (fifo_count)
    );

    assign m_tvalid = (fifo_count != '0);
    assign m_tdata  = {1'b0, head.by, head.bx, head.pix};
    assign m_tlast  = head.last;

endmodule

// ===== test/gmbs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmbs_checker
// watches the pixel, sample and register channels, predicts every block
// sample from the accepted pixels and compares it with the sample received
// ----------------------------------------------------------------------------
module gmbs_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    input  logic                         s_tready,
    input  logic [63:0]                  s_tdata,
    input  logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic [87:0]                  m_tdata,
    input  logic                         m_tlast,
    input  logic                         cfg_we,
    input  logic [gmbs_pkg::IDX_W-1:0]   cfg_index,
    input  logic [gmbs_pkg::REG_W-1:0]   cfg_data,
    output int                           fail_count,
    output int                           pending
);

    typedef struct {
        logic [87:0] data;
        logic        last;
    } sample_t;

    logic [15:0] upper_ch0 [gmbs_pkg::MAX_WIDTH];
    logic [63:0] mid_row [gmbs_pkg::MAX_WIDTH];
    logic [15:0] best_grad [gmbs_pkg::MAX_WIDTH];
    logic [63:0] best_pix [gmbs_pkg::MAX_WIDTH];
    logic [63:0] left_pix;
    int unsigned col, row;
    int unsigned reg_w, reg_h, reg_bs;
    sample_t samples_due[$];
    sample_t fresh[$];

    function automatic logic [15:0] absdiff(logic [15:0] a, logic [15:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic logic [15:0] gradient(logic [15:0] c, logic [15:0] l,
                                             logic [15:0] r, logic [15:0] u,
                                             logic [15:0] d);
        logic [15:0] m;
        m = absdiff(c, l);
        if (absdiff(c, r) > m) m = absdiff(c, r);
        if (absdiff(c, u) > m) m = absdiff(c, u);
        if (absdiff(c, d) > m) m = absdiff(c, d);
        return m;
    endfunction

    function automatic sample_t make_sample(logic [63:0] p, int unsigned bx,
                                            int unsigned by);
        sample_t s;
        s.data = {by[11:0], bx[10:0], p};
        s.last = 1'b0;
        return s;
    endfunction

    task automatic add_to_block(int unsigned px, int unsigned py, logic [15:0] g,
                                logic [63:0] p, int unsigned bs);
        int unsigned bx, by, lx, ly;
        bx = px / bs;
        by = py / bs;
        lx = px % bs;
        ly = py % bs;
        if (bx < gmbs_pkg::MAX_WIDTH)
        begin
            if ((lx == 0 && ly == 0) || g > best_grad[bx])
            begin
                best_grad[bx] = g;
                best_pix[bx]  = p;
            end
            if (lx == bs - 1 && ly == bs - 1)
                fresh.push_back(make_sample(best_pix[bx], bx, by));
        end
    endtask

    task automatic take_pixel(logic [63:0] p);
        int unsigned w, h, bs, x, y, px;
        logic [15:0] cc, r, u, g;
        w  = (reg_w < 1) ? 1 :
             (reg_w > gmbs_pkg::MAX_WIDTH ? gmbs_pkg::MAX_WIDTH : reg_w);
        h  = (reg_h < 1) ? 1 : reg_h;
        bs = (reg_bs < 1) ? 1 :
             (reg_bs > gmbs_pkg::MAX_BLOCK ? gmbs_pkg::MAX_BLOCK : reg_bs);
        if (col >= w || row >= h)
        begin
            col = 0;
            row = 0;
        end
        x = col;
        y = row;
        fresh.delete();
        if (bs == 1)
            fresh.push_back(make_sample(p, x, y));
        if (y >= 1)
        begin
            cc = mid_row[x][15:0];
            r  = (x + 1 < w) ? mid_row[x + 1][15:0] : cc;
            u  = (y == 1) ? cc : upper_ch0[x];
            g  = (x == 0 || x == w - 1) ? 16'd0 : gradient(cc, left_pix[15:0], r, u, p[15:0]);
            if (bs > 1)
                add_to_block(x, y - 1, g, mid_row[x], bs);
            left_pix     = mid_row[x];
            upper_ch0[x] = cc;
        end
        mid_row[x] = p;
        if (y == h - 1 && bs > 1)
        begin
            if (x >= 1)
            begin
                px = x - 1;
                cc = mid_row[px][15:0];
                g  = 16'd0;
                if (px != 0)
                begin
                    u = (y == 0) ? cc : upper_ch0[px];
                    g = gradient(cc, mid_row[px - 1][15:0], p[15:0], u, cc);
                end
                add_to_block(px, y, g, mid_row[px], bs);
            end
            if (x == w - 1)
                add_to_block(x, y, 16'd0, mid_row[x], bs);
        end
        if (fresh.size() > 0)
            fresh[fresh.size() - 1].last = 1'b1;
        foreach (fresh[i])
            samples_due.push_back(fresh[i]);
        col = x + 1;
        if (col >= w)
        begin
            col = 0;
            row = y + 1;
            if (row >= h)
                row = 0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        sample_t want;
        if (!rst_n)
        begin
            fail_count = 0;
            pending = 0;
            col = 0;
            row = 0;
            left_pix = '0;
            reg_w = 64;
            reg_h = 64;
            reg_bs = 2;
            samples_due.delete();
        end
        else
        begin
            // sample first: a pixel's results are never sent out while that pixel is being taken
            if (m_tvalid && m_tready)
            begin
                if (samples_due.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected sample data=%h last=%b", m_tdata, m_tlast);
                end
                else
                begin
                    want = samples_due.pop_front();
                    if (want.data !== m_tdata || want.last !== m_tlast)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $display("sample mismatch: expected pix=%h bx=%0d by=%0d last=%b",
                                     want.data[63:0], want.data[74:64], want.data[86:75],
                                     want.last);
                            $display("                 got      pix=%h bx=%0d by=%0d last=%b",
                                     m_tdata[63:0], m_tdata[74:64], m_tdata[86:75],
                                     m_tlast);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready)
                take_pixel(s_tdata);
            if (cfg_we)
            begin
                case (cfg_index)
                    gmbs_pkg::CFG_ROI_WIDTH:  reg_w  = cfg_data;
                    gmbs_pkg::CFG_ROI_HEIGHT: reg_h  = cfg_data;
                    gmbs_pkg::CFG_BLOCK_SIZE: reg_bs = cfg_data[gmbs_pkg::BS_W-1:0];
                    default: ;
                endcase
                if (cfg_index == gmbs_pkg::CFG_ROI_WIDTH ||
                    cfg_index == gmbs_pkg::CFG_ROI_HEIGHT ||
                    cfg_index == gmbs_pkg::CFG_BLOCK_SIZE)
                begin
                    col = 0;
                    row = 0;
                end
            end
            pending = samples_due.size();
        end
    end

endmodule

// ===== test/gradient_max_block_sampler_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gradient_max_block_sampler_unit_test
// drives frames of random pixels through the sampler under several region and
// block settings with random stalls on both sides; the checker predicts
// ----------------------------------------------------------------------------
module gradient_max_block_sampler_unit_test;

    localparam int LIMIT = 20000;

    logic                         clk;
    logic                         rst_n;
    logic                         s_tvalid;
    logic                         s_tready;
    logic [63:0]                  s_tdata;
    logic                         m_tvalid;
    logic                         m_tready;
    logic [87:0]                  m_tdata;
    logic                         m_tlast;
    logic                         cfg_we;
    logic [gmbs_pkg::IDX_W-1:0]   cfg_index;
    logic [gmbs_pkg::REG_W-1:0]   cfg_data;
    int                           fail_count;
    int                           pending;
    int                           send_idle;
    int                           recv_idle;
    int                           quiet;
    int                           pix_mode;

    gradient_max_block_sampler_unit dut (.*);

    gmbs_checker checker_i (.*);

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= recv_idle);

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic [15:0] rand_sample();
        case (pix_mode)
            0: return ($urandom_range(1)) ? 16'hFFFF : 16'h0000;
            1: return 16'(32768 + $urandom_range(7) - 4);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_pixel(logic [63:0] p);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= p;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(logic [gmbs_pkg::IDX_W-1:0] idx,
                             logic [gmbs_pkg::REG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic run_frame(int w, int h, int bs, int n);
        drain();
        write_reg(gmbs_pkg::CFG_ROI_WIDTH, w[gmbs_pkg::REG_W-1:0]);
        write_reg(gmbs_pkg::CFG_ROI_HEIGHT, h[gmbs_pkg::REG_W-1:0]);
        write_reg(gmbs_pkg::CFG_BLOCK_SIZE, bs[gmbs_pkg::REG_W-1:0]);
        repeat (n)
            send_pixel({rand_sample(), rand_sample(), rand_sample(), rand_sample()});
    endtask

    initial
    begin
        int k;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = gmbs_pkg::CFG_ROI_WIDTH;
        cfg_data  = '0;
        quiet     = 0;
        send_idle = 34;
        recv_idle = 45;
        pix_mode  = 0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        // directed: extreme values at reset settings, block size one, single row
        send_pixel('0);
        send_pixel('1);
        send_pixel({4{16'h8000}});
        run_frame(4, 4, 1, 6);
        run_frame(6, 1, 2, 6);
        run_frame(1, 4, 1, 4);
        run_frame(4, 4, 4, 16);
        for (k = 0; k < 3; k++)
        begin
            if (k == 1)
            begin
                send_idle = 45;
                recv_idle = 34;
            end
            if (k == 2)
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            pix_mode = 2;
            run_frame(8, 8, 2, 64);
            pix_mode = 1;
            run_frame(6, 4, 3, 24);
            pix_mode = $urandom_range(2);
            if (k == 0)
                run_frame(16, 16, 16, 256);
            run_frame(5, 7, 2, 40);
            run_frame(2048, 1, 31, 24);
            pix_mode = 2;
            run_frame(0, 0, 0, 8);
            run_frame(3 + $urandom_range(9), 2 + $urandom_range(6),
                      1 + $urandom_range(4), 20);
        end
        drain();
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/gmbs_pkg.sv
rtl/gmbs_ram.sv
rtl/gmbs_out_fifo.sv
rtl/gradient_max_block_sampler_unit.sv
test/gmbs_checker.sv
test/gradient_max_block_sampler_unit_test.sv
